// ===== rtl/lse_pkg.sv =====
`timescale 1ns / 1ps
package lse_pkg;

	localparam int TERM_LEN = 9;
	localparam int LINE_LEN = 8;
	localparam int LINE_AW  = 3;
	localparam int LINE_CW  = 4;
	localparam int QDEPTH   = 4;
	localparam int QAW      = 2;
	localparam int QCW      = 3;

	localparam logic [7:0] TERM_TEXT [TERM_LEN] = '{
		8'h23, 8'h23, 8'h23, 8'h45, 8'h4E, 8'h44, 8'h23, 8'h23, 8'h23
	};

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_FOUND   = 2'd1,
		KIND_MISSING = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic       last_of_run;
	} result_t;

	// what one pixel leaves for the back end
	typedef struct packed {
		logic       byte_vld;
		logic       found;
		logic [7:0] data;
		logic       end_vld;
	} evt_t;

endpackage

// ===== rtl/lsb_stego_extract_top.sv =====
`timescale 1ns / 1ps
// LSB steganography extractor. Push one RGB pixel per cycle in raster order; the LSBs
// of red, green and blue are packed MSB first into bytes, and the byte stream is
// searched for the terminator "###END###". Bytes that can no longer begin the
// terminator come out as tentative message bytes (kind 0); a match gives kind 1, and
// a last pixel without a match gives kind 2. A zero byte stops the search. A pixel is
// taken every cycle while full is low; its results pass through the event queue and
// the registered result stage before they reach the result ports. While results are
// popped the result side delivers one result per cycle, so a pixel with two results
// holds the back end for both, and a 4-entry event queue between the classifying
// front end and the result back end absorbs such bursts.
module lsb_stego_extract_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  lse_pkg::pixel_t  pixel,
	output logic             empty,
	input  logic             pop,
	output lse_pkg::result_t result
);
	import lse_pkg::*;

	logic evt_push;
	evt_t evt_in;
	logic q_full;
	logic q_pop;
	evt_t q_data;
	logic q_empty;

	lse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.evt_push (evt_push),
		.evt      (evt_in),
		.q_full   (q_full)
	);

	lse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (evt_push),
		.wdata  (evt_in),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	lse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== rtl/lse_front.sv =====
`timescale 1ns / 1ps
module lse_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lse_pkg::pixel_t pixel,
	output logic            evt_push,
	output lse_pkg::evt_t   evt,
	input  logic            q_full
);
	import lse_pkg::*;

	logic [7:0]         acc_q;
	logic [2:0]         held_q;
	logic [7:0]         line_q [LINE_LEN];
	logic [LINE_CW-1:0] cnt_q;
	logic               done_q;
	logic               seen_q;

	logic        accept;
	logic [10:0] wide;
	logic [7:0]  nb;
	logic [7:0]  nacc;
	logic [2:0]  nheld;
	logic        byte_rdy;
	logic        hit;
	logic        take;
	logic        found;
	logic        emit;
	logic        store;
	logic        end_vld;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign wide   = {acc_q, pixel.red[0], pixel.green[0], pixel.blue[0]};

	// unused high bits of acc_q are always zero
	always_comb begin
		byte_rdy = 1'b1;
		unique case (held_q)
			3'd5: begin
				nb    = wide[7:0];
				nacc  = 8'd0;
				nheld = 3'd0;
			end
			3'd6: begin
				nb    = wide[8:1];
				nacc  = {7'd0, wide[0]};
				nheld = 3'd1;
			end
			3'd7: begin
				nb    = wide[9:2];
				nacc  = {6'd0, wide[1:0]};
				nheld = 3'd2;
			end
			default: begin
				byte_rdy = 1'b0;
				nb       = wide[7:0];
				nacc     = wide[7:0];
				nheld    = held_q + 3'd3;
			end
		endcase
	end

	always_comb begin
		hit = (nb == TERM_TEXT[TERM_LEN-1]);
		for (int i = 0; i < LINE_LEN; i++) begin
			hit = hit && (line_q[i] == TERM_TEXT[i]);
		end
	end

	// a zero byte ends the search like a string terminator
	assign take    = byte_rdy && !done_q && (nb != 8'd0);
	assign found   = take && cnt_q[LINE_AW] && hit;
	assign emit    = take && cnt_q[LINE_AW] && !hit;
	assign store   = take && !cnt_q[LINE_AW];
	assign end_vld = pixel.last_pixel && !(seen_q || found);

	assign evt.byte_vld = found || emit;
	assign evt.found    = found;
	assign evt.data     = found ? 8'd0 : line_q[0];
	assign evt.end_vld  = end_vld;
	assign evt_push     = accept && (found || emit || end_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (pixel.last_pixel) begin
				acc_q  <= '0;
				held_q <= '0;
				cnt_q  <= '0;
				done_q <= 1'b0;
				seen_q <= 1'b0;
			end else begin
				acc_q  <= nacc;
				held_q <= nheld;
				if (store) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (byte_rdy && (nb == 8'd0 || found)) begin
					done_q <= 1'b1;
				end
				if (found) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	// line contents past cnt_q are never read, so no reset needed
	always_ff @(posedge clk) begin
		if (accept && !pixel.last_pixel) begin
			if (emit) begin
				for (int i = 0; i < LINE_LEN - 1; i++) begin
					line_q[i] <= line_q[i+1];
				end
				line_q[LINE_LEN-1] <= nb;
			end else if (store) begin
				line_q[cnt_q[LINE_AW-1:0]] <= nb;
			end
		end
	end

endmodule

// ===== rtl/lse_queue.sv =====
`timescale 1ns / 1ps
module lse_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  lse_pkg::evt_t wdata,
	output logic          full,
	input  logic          rd,
	output lse_pkg::evt_t rdata,
	output logic          empty
);
	import lse_pkg::*;

	evt_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QCW-1:0] cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = (cnt_q == QCW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// ===== rtl/lse_back.sv =====
`timescale 1ns / 1ps
module lse_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  lse_pkg::evt_t    q_data,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output lse_pkg::result_t result
);
	import lse_pkg::*;

	logic    out_vld_q;
	result_t res_q;
	logic    end_pend_q;

	result_t res_n;
	logic    adv;
	logic    set_pend;
	logic    go;

	// one result per cycle while the output is popped; a pixel with two results stays in the queue until its second is out
	always_comb begin
		set_pend = 1'b0;
		adv      = 1'b1;
		if (end_pend_q || !q_data.byte_vld) begin
			res_n = '{out_byte: 8'd0, kind: KIND_MISSING, last_of_run: 1'b1};
		end else begin
			res_n = '{out_byte: q_data.data,
			          kind: q_data.found ? KIND_FOUND : KIND_BYTE,
			          last_of_run: !q_data.end_vld};
			adv      = !q_data.end_vld;
			set_pend = q_data.end_vld;
		end
	end

	assign go     = (!out_vld_q || pop) && !q_empty;
	assign q_pop  = go && adv;
	assign empty  = !out_vld_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			end_pend_q <= 1'b0;
		end else if (go) begin
			out_vld_q  <= 1'b1;
			end_pend_q <= set_pend;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_n;
		end
	end

endmodule

// ===== rtl/lse_checker.sv =====
`timescale 1ns / 1ps
module lse_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input lse_pkg::pixel_t  pixel,
	input logic             empty,
	input logic             pop,
	input lse_pkg::result_t result
);
	import lse_pkg::*;

	// reports carry no byte and always close a pixel's run
	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != KIND_BYTE) |-> (result.out_byte == 8'd0 && result.last_of_run))
		else $error("report item with byte or not last of run");

	// a message byte is never zero, since zero ends the search
	a_byte_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_BYTE) |-> (result.out_byte != 8'd0))
		else $error("zero message byte emitted");

	// a byte that does not close its run is followed at once by the missing report
	a_byte_then_report: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && result.kind == KIND_BYTE && !result.last_of_run)
		|=> (!empty && result.kind == KIND_MISSING))
		else $error("missing report did not follow open byte item");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.kind == KIND_BYTE || result.kind == KIND_FOUND ||
		            result.kind == KIND_MISSING))
		else $error("illegal kind code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled item changed");

endmodule

bind lsb_stego_extract_top lse_checker u_lse_checker (.*);
